FILE: hdl/tbms_pkg.sv
// shared types and constants for the two-wire bus master sequencer
// transfer structs, configuration layout, command codes and reset values
// no dependencies
package tbms_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_CLOCKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TRIES       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAKE_CLOCKS     = 2'd2;

	localparam logic [7:0] RST_POWER_ON_CLOCKS = 8'd15;
	localparam logic [7:0] RST_ACK_TRIES       = 8'd8;
	localparam logic [7:0] RST_WAKE_CLOCKS     = 8'd15;

	localparam logic [3:0] CMD_TICK      = 4'd0;
	localparam logic [3:0] CMD_POWER_ON  = 4'd1;
	localparam logic [3:0] CMD_POWER_OFF = 4'd2;
	localparam logic [3:0] CMD_START     = 4'd3;
	localparam logic [3:0] CMD_STOP      = 4'd4;
	localparam logic [3:0] CMD_WRITE     = 4'd5;
	localparam logic [3:0] CMD_READ      = 4'd6;
	localparam logic [3:0] CMD_ACK_NAK   = 4'd7;
	localparam logic [3:0] CMD_WAKE      = 4'd8;

	typedef struct packed {
		logic [3:0] command;
		logic [7:0] data_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic [7:0] ack_failures;
	} result_t;

	typedef struct packed {
		logic [7:0] power_on_clocks;
		logic [7:0] ack_tries;
		logic [7:0] wake_clocks;
	} cfg_t;

endpackage

FILE: hdl/tbms_seq.sv
// bus sequencer state and next-step logic, one pin action per advance
// depends on tbms_pkg
module tbms_seq
	import tbms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_PON_DH   = 5'd1,
		PH_PON_CL   = 5'd2,
		PH_CYC_LO   = 5'd3,
		PH_CYC_HI   = 5'd4,
		PH_FINAL_CL = 5'd5,
		PH_ST_CL    = 5'd6,
		PH_ST_DH    = 5'd7,
		PH_ST_CH    = 5'd8,
		PH_ST_DL    = 5'd9,
		PH_ST_CL2   = 5'd10,
		PH_SP_CL    = 5'd11,
		PH_SP_DL    = 5'd12,
		PH_SP_CH    = 5'd13,
		PH_SP_DH    = 5'd14,
		PH_W_CL     = 5'd15,
		PH_W_DATA   = 5'd16,
		PH_W_CH     = 5'd17,
		PH_W_CL_ACK = 5'd18,
		PH_W_DH     = 5'd19,
		PH_W_CH_ACK = 5'd20,
		PH_W_SAMPLE = 5'd21,
		PH_R_DH     = 5'd22,
		PH_R_CL     = 5'd23,
		PH_R_CH     = 5'd24,
		PH_R_SAMPLE = 5'd25,
		PH_R_CL2    = 5'd26,
		PH_AK_CL    = 5'd27,
		PH_AK_DATA  = 5'd28,
		PH_AK_CH    = 5'd29,
		PH_WK_DL    = 5'd30
	} step_t;

	step_t      step_q, step_n, cur;
	logic [3:0] cmd_q, cmd_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] shift_q, shift_n;
	logic [7:0] pulse_q, pulse_n;
	logic [7:0] rep_q, rep_n;
	logic [7:0] try_q, try_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic [7:0] rd_q, rd_n;
	logic [7:0] fail_q, fail_n;
	logic       done;
	logic       is_wake;
	logic [7:0] tgt;
	logic       start;

	always_comb begin
		step_n  = step_q;
		cmd_n   = cmd_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		pulse_n = pulse_q;
		rep_n   = rep_q;
		try_n   = try_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		rd_n    = rd_q;
		fail_n  = fail_q;
		done    = 1'b0;

		// a command is taken only while idle; tick-only and unknown codes do nothing
		start = (step_q == PH_IDLE) && (item.command >= CMD_POWER_ON) &&
			(item.command <= CMD_WAKE);
		if (start) begin
			cmd_n   = item.command;
			bit_n   = 4'd0;
			try_n   = 8'd0;
			pulse_n = 8'd0;
			case (item.command)
				CMD_POWER_ON:  step_n = PH_PON_DH;
				CMD_POWER_OFF: step_n = PH_FINAL_CL;
				CMD_START:     step_n = PH_ST_CL;
				CMD_STOP:      step_n = PH_SP_CL;
				CMD_WRITE: begin
					shift_n = item.data_byte;
					step_n  = PH_W_CL;
				end
				CMD_READ: begin
					shift_n = 8'd0;
					step_n  = PH_R_DH;
				end
				CMD_ACK_NAK: begin
					shift_n = {7'd0, |item.data_byte};
					step_n  = PH_AK_CL;
				end
				default: begin
					rep_n  = item.data_byte;
					step_n = PH_WK_DL;
				end
			endcase
		end

		is_wake = (cmd_n == CMD_WAKE);
		tgt     = is_wake ? cfg.wake_clocks : cfg.power_on_clocks;
		cur     = step_n;

		case (cur)
			PH_IDLE: ;
			PH_PON_DH: begin
				sda_n  = 1'b1;
				step_n = PH_PON_CL;
			end
			PH_PON_CL: begin
				scl_n   = 1'b0;
				pulse_n = 8'd0;
				if (tgt != 8'd0) begin
					step_n = PH_CYC_LO;
				end else begin
					step_n = PH_IDLE;
					done   = 1'b1;
				end
			end
			PH_CYC_LO: begin
				scl_n  = 1'b0;
				step_n = PH_CYC_HI;
			end
			PH_CYC_HI: begin
				scl_n   = 1'b1;
				pulse_n = pulse_q + 8'd1;
				if (pulse_n < tgt) begin
					step_n = PH_CYC_LO;
				end else if (is_wake) begin
					step_n = PH_SP_CL;
				end else begin
					step_n = PH_IDLE;
					done   = 1'b1;
				end
			end
			PH_FINAL_CL: begin
				scl_n  = 1'b0;
				step_n = PH_IDLE;
				done   = 1'b1;
			end
			PH_ST_CL: begin
				scl_n  = 1'b0;
				step_n = PH_ST_DH;
			end
			PH_ST_DH: begin
				sda_n  = 1'b1;
				step_n = PH_ST_CH;
			end
			PH_ST_CH: begin
				scl_n  = 1'b1;
				step_n = PH_ST_DL;
			end
			PH_ST_DL: begin
				sda_n  = 1'b0;
				step_n = PH_ST_CL2;
			end
			PH_ST_CL2: begin
				scl_n = 1'b0;
				if (is_wake) begin
					// wake goes on to its clock run, or straight to stop
					pulse_n = 8'd0;
					step_n  = (tgt != 8'd0) ? PH_CYC_LO : PH_SP_CL;
				end else begin
					step_n = PH_IDLE;
					done   = 1'b1;
				end
			end
			PH_SP_CL: begin
				scl_n  = 1'b0;
				step_n = PH_SP_DL;
			end
			PH_SP_DL: begin
				sda_n  = 1'b0;
				step_n = PH_SP_CH;
			end
			PH_SP_CH: begin
				scl_n  = 1'b1;
				step_n = PH_SP_DH;
			end
			PH_SP_DH: begin
				sda_n = 1'b1;
				if (is_wake && rep_q > 8'd1) begin
					rep_n  = rep_q - 8'd1;
					step_n = PH_ST_CL;
				end else begin
					if (is_wake)
						rep_n = 8'd0;
					step_n = PH_IDLE;
					done   = 1'b1;
				end
			end
			PH_W_CL: begin
				scl_n  = 1'b0;
				step_n = PH_W_DATA;
			end
			PH_W_DATA: begin
				sda_n  = shift_n[7];
				step_n = PH_W_CH;
			end
			PH_W_CH: begin
				scl_n   = 1'b1;
				shift_n = {shift_q[6:0], 1'b0};
				bit_n   = bit_q + 4'd1;
				step_n  = (bit_n >= 4'd8) ? PH_W_CL_ACK : PH_W_CL;
			end
			PH_W_CL_ACK: begin
				scl_n  = 1'b0;
				step_n = PH_W_DH;
			end
			PH_W_DH: begin
				sda_n  = 1'b1;
				step_n = PH_W_CH_ACK;
			end
			PH_W_CH_ACK: begin
				scl_n = 1'b1;
				try_n = 8'd0;
				if (cfg.ack_tries == 8'd0) begin
					fail_n = 8'd0;
					step_n = PH_FINAL_CL;
				end else begin
					step_n = PH_W_SAMPLE;
				end
			end
			PH_W_SAMPLE: begin
				sda_n = 1'b1;
				if (!item.sda_in) begin
					fail_n = 8'd0;
					step_n = PH_FINAL_CL;
				end else begin
					try_n = try_q + 8'd1;
					if (try_n >= cfg.ack_tries) begin
						fail_n = try_n;
						step_n = PH_FINAL_CL;
					end
				end
			end
			PH_R_DH: begin
				sda_n  = 1'b1;
				step_n = PH_R_CL;
			end
			PH_R_CL: begin
				scl_n  = 1'b0;
				step_n = PH_R_CH;
			end
			PH_R_CH: begin
				scl_n  = 1'b1;
				step_n = PH_R_SAMPLE;
			end
			PH_R_SAMPLE: begin
				sda_n   = 1'b1;
				shift_n = {shift_q[6:0], item.sda_in};
				step_n  = PH_R_CL2;
			end
			PH_R_CL2: begin
				scl_n = 1'b0;
				bit_n = bit_q + 4'd1;
				if (bit_n >= 4'd8) begin
					rd_n   = shift_q;
					step_n = PH_IDLE;
					done   = 1'b1;
				end else begin
					step_n = PH_R_CL;
				end
			end
			PH_AK_CL: begin
				scl_n  = 1'b0;
				step_n = PH_AK_DATA;
			end
			PH_AK_DATA: begin
				sda_n  = ~(|shift_n);
				step_n = PH_AK_CH;
			end
			PH_AK_CH: begin
				scl_n  = 1'b1;
				step_n = PH_FINAL_CL;
			end
			PH_WK_DL: begin
				sda_n = 1'b0;
				if (rep_n == 8'd0) begin
					step_n = PH_IDLE;
					done   = 1'b1;
				end else begin
					step_n = PH_ST_CL;
				end
			end
			default: step_n = PH_IDLE;
		endcase

		res.scl_release  = scl_n;
		res.sda_release  = sda_n;
		res.busy_res     = (step_n != PH_IDLE);
		res.done_res     = done;
		res.read_byte    = rd_n;
		res.ack_failures = fail_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= PH_IDLE;
			cmd_q   <= CMD_TICK;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			pulse_q <= 8'd0;
			rep_q   <= 8'd0;
			try_q   <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rd_q    <= 8'd0;
			fail_q  <= 8'd0;
		end else if (advance) begin
			step_q  <= step_n;
			cmd_q   <= cmd_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			pulse_q <= pulse_n;
			rep_q   <= rep_n;
			try_q   <= try_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			rd_q    <= rd_n;
			fail_q  <= fail_n;
		end
	end

endmodule

FILE: hdl/two_wire_bus_master_sequencer_top.sv
// top level of the two-wire bus master sequencer: handshakes, config registers,
// result register; depends on tbms_pkg and tbms_seq
//
//   channel  | signals                           | direction
//   ---------+-----------------------------------+----------
//   command  | cmd_valid, cmd_stall, cmd_data    | in
//   result   | res_valid, res_stall, res_data    | out
//   config   | cfg_we, cfg_index, cfg_wdata      | in
//
// one bus tick per command transfer; each transfer's result is registered and shown in the cycle after it
// a new command can be taken every cycle while cmd_stall is low
// the result register lets a command in while the previous result is read out the same cycle
// res_stall holds the result register and stalls the command side only while it is full
// reset releases both bus lines and restores the default config values
module two_wire_bus_master_sequencer_top
	import tbms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  item_t                 cmd_data,
	output logic                  res_valid,
	input  logic                  res_stall,
	output result_t               res_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	result_t res_next;
	result_t res_q;
	logic    res_valid_q;
	logic    accept;

	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;

	tbms_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.item   (cmd_data),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_on_clocks <= RST_POWER_ON_CLOCKS;
			cfg_q.ack_tries       <= RST_ACK_TRIES;
			cfg_q.wake_clocks     <= RST_WAKE_CLOCKS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POWER_ON_CLOCKS: cfg_q.power_on_clocks <= cfg_wdata;
				CFG_ACK_TRIES:       cfg_q.ack_tries       <= cfg_wdata;
				CFG_WAKE_CLOCKS:     cfg_q.wake_clocks     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			res_q <= res_next;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

FILE: hdl/tbms_chk.sv
// port-level checker for the two-wire bus master sequencer, with its bind
// depends on tbms_pkg and two_wire_bus_master_sequencer_top
module tbms_chk
	import tbms_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    cmd_valid,
	input logic    cmd_stall,
	input item_t   cmd_data,
	input logic    res_valid,
	input logic    res_stall,
	input result_t res_data
);

	logic last_busy_q;
	logic idle_now;

	// busy flag of the last result taken; idle_now falls back on it when no result is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_busy_q <= 1'b0;
		else if (res_valid && !res_stall)
			last_busy_q <= res_data.busy_res;
	end

	assign idle_now = res_valid ? !res_data.busy_res : !last_busy_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.done_res && res_data.busy_res))
		else $error("result shows done and busy together");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed or dropped");

	a_cmd_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("command transfer gave no result next cycle");

	a_power_off: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && idle_now && cmd_data.command == CMD_POWER_OFF
		|=> !res_data.scl_release && res_data.done_res && !res_data.busy_res)
		else $error("power off from idle did not pull the clock low and finish");

endmodule

bind two_wire_bus_master_sequencer_top tbms_chk u_tbms_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd_data (cmd_data),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);
